/* hw/rtl/fspa_pkg.sv */
// fspa_pkg: types, codes and sizes shared by the fixed slot pool allocator
// no dependencies; fspa_ctrl, fspa_dp and the top level use it by scoped names
`default_nettype none

package fspa_pkg;

  // pool limits
  localparam int unsigned MAX_SLOTS      = 256;
  localparam int unsigned MAX_SLOT_WORDS = 4096;

  // field widths
  localparam int unsigned CNT_W  = 9;   // slot counts, 0 .. MAX_SLOTS
  localparam int unsigned WRD_W  = 13;  // words per slot
  localparam int unsigned OFF_W  = 20;  // word offsets
  localparam int unsigned STAT_W = 3;
  localparam int unsigned ADDR_W = $clog2(MAX_SLOTS);
  localparam int unsigned EXT_W  = CNT_W + WRD_W;
  localparam int unsigned CIDX_W = 2;

  // input operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_SLOT_COUNT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_SLOT_WORDS = 2'd1;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NULL      = 3'd1,
    STAT_EXHAUSTED = 3'd2,
    STAT_RANGE     = 3'd3,
    STAT_NONE      = 3'd4
  } status_e;

  // controller states
  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_POP  = 1'b1
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic accept;     // input word taken this edge
    logic load_pop;   // finish an allocate from the stack read
    logic cfg_write;  // configuration word taken this edge
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic needs_pop;  // the word at the input is an allocate that pops
  } dp_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/fspa_ram.sv */
// fspa_ram: generic single write, single read RAM with registered read data
// no dependencies
`default_nettype none

module fspa_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/fspa_ctrl.sv */
// fspa_ctrl: handshake controller of the slot pool allocator
// depends on fspa_pkg; drives the datapath through dp_cmd_t, reads dp_sts_t
`default_nettype none

module fspa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  output fspa_pkg::dp_cmd_t cmd_o,
  input  fspa_pkg::dp_sts_t sts_i
);

  fspa_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic in_acc;

  // input taken only when idle, with no config word waiting, and the output
  // register free or draining
  assign in_ready_o  = (state_q == fspa_pkg::CTRL_IDLE) && !cfg_valid_i &&
                       (!out_valid_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = (state_q == fspa_pkg::CTRL_IDLE);
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fspa_pkg::CTRL_IDLE: begin
        if (in_acc && sts_i.needs_pop) begin
          state_d = fspa_pkg::CTRL_POP;
        end
      end
      fspa_pkg::CTRL_POP: begin
        state_d = fspa_pkg::CTRL_IDLE;
      end
      default: state_d = fspa_pkg::CTRL_IDLE;
    endcase
  end

  // commands and output valid
  always_comb begin
    cmd_o           = '0;
    cmd_o.accept    = in_acc;
    cmd_o.cfg_write = cfg_valid_i && cfg_ready_o;
    out_valid_d     = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      fspa_pkg::CTRL_IDLE: begin
        if (in_acc && !sts_i.needs_pop) begin
          out_valid_d = 1'b1;
        end
      end
      fspa_pkg::CTRL_POP: begin
        cmd_o.load_pop = 1'b1;
        out_valid_d    = 1'b1;
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fspa_pkg::CTRL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register is empty while a pop is finishing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fspa_pkg::CTRL_POP) |-> !out_valid_q)
    else $error("output register busy during pop");

  // a pop always ends, back in idle with a result registered in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fspa_pkg::CTRL_POP) |=> (state_q == fspa_pkg::CTRL_IDLE) && out_valid_q)
    else $error("pop did not complete");

  // a request word and a config word never land on the same edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && cmd_o.cfg_write))
    else $error("request taken together with config write");

endmodule

`default_nettype wire

/* hw/rtl/fspa_dp.sv */
// fspa_dp: datapath of the slot pool allocator: config, counters, free stack, result
// depends on fspa_pkg and fspa_ram
`default_nettype none

module fspa_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fspa_pkg::dp_cmd_t             cmd_i,
  output fspa_pkg::dp_sts_t             sts_o,
  input  logic                          op_i,
  input  logic                          free_is_null_i,
  input  logic [fspa_pkg::OFF_W-1:0]    free_offset_i,
  input  logic [fspa_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [fspa_pkg::WRD_W-1:0]    cfg_data_i,
  output logic [fspa_pkg::STAT_W-1:0]   status_o,
  output logic [fspa_pkg::OFF_W-1:0]    slot_offset_o,
  output logic [fspa_pkg::CNT_W-1:0]    free_count_o,
  output logic [fspa_pkg::CNT_W-1:0]    allocated_count_o
);

  localparam int unsigned CW = fspa_pkg::CNT_W;
  localparam int unsigned WW = fspa_pkg::WRD_W;
  localparam int unsigned OW = fspa_pkg::OFF_W;
  localparam int unsigned AW = fspa_pkg::ADDR_W;
  localparam int unsigned EW = fspa_pkg::EXT_W;
  localparam logic [CW-1:0] MAX_CNT   = CW'(fspa_pkg::MAX_SLOTS);
  localparam logic [WW-1:0] MAX_WORDS = WW'(fspa_pkg::MAX_SLOT_WORDS);

  // effective (saturated) configuration
  logic [CW-1:0] cnt_q;
  logic [WW-1:0] words_q;
  // stack depth and allocated count
  logic [CW-1:0] depth_q, depth_d;
  logic [CW-1:0] in_use_q, in_use_d;
  // one bit per stack entry: pushed since the last refill
  logic [fspa_pkg::MAX_SLOTS-1:0] written_q;
  logic          hit_q;
  logic [OW-1:0] refill_q;
  // result register
  fspa_pkg::status_e status_q;
  logic [OW-1:0] offset_q;
  logic [CW-1:0] free_cnt_q;
  logic [CW-1:0] alloc_cnt_q;

  fspa_pkg::status_e stat;
  logic          pop_go, push_go;
  logic [EW-1:0] extent;
  logic [EW-1:0] refill_prod;
  logic [CW-1:0] refill_diff;
  logic [CW-1:0] depth_dec;
  logic [AW-1:0] pop_addr, push_addr;
  logic [OW-1:0] ram_rdata;
  logic [CW-1:0] new_cnt;
  logic [WW-1:0] new_words;

  // pool extent and the refill offset of the top stack entry
  assign extent      = EW'(cnt_q) * EW'(words_q);
  assign refill_diff = cnt_q - depth_q;
  assign refill_prod = EW'(refill_diff) * EW'(words_q);
  assign depth_dec   = depth_q - CW'(1);
  assign pop_addr    = depth_dec[AW-1:0];
  assign push_addr   = depth_q[AW-1:0];

  // saturate configuration words; the slot count is cut to its low CNT_W bits first
  always_comb begin
    new_cnt = cfg_data_i[CW-1:0];
    if (new_cnt > MAX_CNT) begin
      new_cnt = MAX_CNT;
    end
    new_words = cfg_data_i;
    if (new_words == '0) begin
      new_words = WW'(1);
    end else if (new_words > MAX_WORDS) begin
      new_words = MAX_WORDS;
    end
  end

  // request decode
  always_comb begin
    stat    = fspa_pkg::STAT_OK;
    pop_go  = 1'b0;
    push_go = 1'b0;
    if (op_i == fspa_pkg::OP_ALLOC) begin
      if (depth_q == '0) begin
        stat = fspa_pkg::STAT_EXHAUSTED;
      end else begin
        pop_go = 1'b1;
      end
    end else if (free_is_null_i) begin
      stat = fspa_pkg::STAT_NULL;
    end else if ((cnt_q != '0) && (EW'(free_offset_i) >= extent)) begin
      stat = fspa_pkg::STAT_RANGE;
    end else if (in_use_q == '0) begin
      stat = fspa_pkg::STAT_NONE;
    end else if (depth_q >= MAX_CNT) begin
      stat = fspa_pkg::STAT_NONE;
    end else begin
      push_go = 1'b1;
    end
  end

  assign sts_o.needs_pop = pop_go;

  // counter updates
  always_comb begin
    depth_d  = depth_q;
    in_use_d = in_use_q;
    if (cmd_i.accept && pop_go) begin
      depth_d  = depth_q - CW'(1);
      in_use_d = in_use_q + CW'(1);
    end else if (cmd_i.accept && push_go) begin
      depth_d  = depth_q + CW'(1);
      in_use_d = in_use_q - CW'(1);
    end
  end

  // config and control registers; a write to a known config index refills the stack
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= MAX_CNT;
      words_q   <= WW'(1);
      depth_q   <= MAX_CNT;
      in_use_q  <= '0;
      written_q <= '0;
    end else if (cmd_i.cfg_write) begin
      case (cfg_index_i)
        fspa_pkg::CFG_SLOT_COUNT: begin
          cnt_q     <= new_cnt;
          depth_q   <= new_cnt;
          in_use_q  <= '0;
          written_q <= '0;
        end
        fspa_pkg::CFG_SLOT_WORDS: begin
          words_q   <= new_words;
          depth_q   <= cnt_q;
          in_use_q  <= '0;
          written_q <= '0;
        end
        default: ;
      endcase
    end else begin
      depth_q  <= depth_d;
      in_use_q <= in_use_d;
      if (cmd_i.accept && push_go) begin
        written_q[push_addr] <= 1'b1;
      end
    end
  end

  // free stack memory
  fspa_ram #(
    .WIDTH(OW),
    .DEPTH(fspa_pkg::MAX_SLOTS)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (cmd_i.accept && push_go),
    .waddr_i(push_addr),
    .wdata_i(free_offset_i),
    .re_i   (cmd_i.accept && pop_go),
    .raddr_i(pop_addr),
    .rdata_o(ram_rdata)
  );

  // pop side info, aligned with the registered stack read
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && pop_go) begin
      hit_q    <= written_q[pop_addr];
      refill_q <= refill_prod[OW-1:0];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pop) begin
      status_q    <= fspa_pkg::STAT_OK;
      offset_q    <= hit_q ? ram_rdata : refill_q;
      free_cnt_q  <= depth_q;
      alloc_cnt_q <= in_use_q;
    end else if (cmd_i.accept && !pop_go) begin
      status_q    <= stat;
      offset_q    <= '0;
      free_cnt_q  <= depth_d;
      alloc_cnt_q <= in_use_d;
    end
  end

  assign status_o          = status_q;
  assign slot_offset_o     = offset_q;
  assign free_count_o      = free_cnt_q;
  assign allocated_count_o = alloc_cnt_q;

  // free plus allocated never exceeds the slot count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, depth_q} + {1'b0, in_use_q}) <= {1'b0, cnt_q})
    else $error("slot accounting broken");

  // a write to a known register refills the stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cfg_write && ((cfg_index_i == fspa_pkg::CFG_SLOT_COUNT) ||
                         (cfg_index_i == fspa_pkg::CFG_SLOT_WORDS)))
    |=> (depth_q == cnt_q) && (in_use_q == '0) && (written_q == '0))
    else $error("refill after config write missing");

  // stack depth stays within the stack memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= MAX_CNT)
    else $error("stack depth past the memory");

endmodule

`default_nettype wire

/* hw/rtl/fixed_slot_pool_allocator_top.sv */
// fixed_slot_pool_allocator_top: top level of the fixed slot pool allocator
// depends on fspa_pkg, fspa_ctrl and fspa_dp (which holds the fspa_ram stack)
`default_nettype none

// Pool allocator for fixed-size slots with a last-in-first-out free stack.
// Each input word is an allocate or a free and gives exactly one result word.
// A free or any rejected request (null, out of range, nothing allocated,
// pool exhausted) has its result in the output register at the next edge,
// so such words can follow one per cycle while the output drains. A
// successful allocate passes through the pop state, because the offset
// comes out of the stack RAM through its registered read port; no request
// word enters until that state is done. A configuration write (index 0
// slot_count, index 1 slot_words, data in cfg_data_i) refills the stack at
// once: per-entry valid bits are cleared together and an entry not pushed
// since reads as its slot offset, so there is no clearing pass after reset
// or config writes. While a config word waits, request words are held off.
module fixed_slot_pool_allocator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic                          free_is_null_i,
  input  logic [fspa_pkg::OFF_W-1:0]    free_offset_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fspa_pkg::STAT_W-1:0]   status_o,
  output logic [fspa_pkg::OFF_W-1:0]    slot_offset_o,
  output logic [fspa_pkg::CNT_W-1:0]    free_count_o,
  output logic [fspa_pkg::CNT_W-1:0]    allocated_count_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fspa_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [fspa_pkg::WRD_W-1:0]    cfg_data_i
);

  fspa_pkg::dp_cmd_t cmd;
  fspa_pkg::dp_sts_t sts;

  // handshake controller
  fspa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // datapath
  fspa_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (op_i),
    .free_is_null_i   (free_is_null_i),
    .free_offset_i    (free_offset_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .status_o         (status_o),
    .slot_offset_o    (slot_offset_o),
    .free_count_o     (free_count_o),
    .allocated_count_o(allocated_count_o)
  );

endmodule

`default_nettype wire
